### design/assert_macros.svh
// Assertion macros used by the state module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that the property holds at every rising edge of clk_i outside reset.
`define DMI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Checks that the expression is never true at a rising edge of clk_i outside reset.
`define DMI_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define DMI_ASSERT(lbl, prop)
`define DMI_ASSERT_NEVER(lbl, expr)
`endif
`endif

### design/dmi_pkg.sv
// Package with the types, constants and step tables of the deadman interlock.
package dmi_pkg;

  localparam int NumButtonsDef = 16;
  localparam int SeqLenDef     = 16;

  localparam int TimeW   = 32;
  localparam int MaskW   = 16;
  localparam int AxisW   = 2;
  localparam int CountW  = 5;
  localparam int GapW    = 16;
  localparam int DeadW   = 4;

  // Progress code reported once the sequence has been activated.
  localparam logic [CountW-1:0] SeqActivated = 5'd17;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegDeadman = 2'd0;
  localparam logic [1:0] RegStepGap = 2'd1;
  localparam logic [1:0] RegHoldoff = 2'd2;

  localparam logic [DeadW-1:0] DeadmanRst = 4'd1;
  localparam logic [GapW-1:0]  StepGapRst = 16'd750;
  localparam logic [GapW-1:0]  HoldoffRst = 16'd1000;

  // Bit i set means step i is checked on the vertical axis, else horizontal.
  localparam logic [15:0] StepIsVert = 16'h00FF;
  // Expected axis value of each step, two-bit two's complement.
  localparam logic [AxisW-1:0] StepValue [16] = '{
    2'b01, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00, 2'b11, 2'b00,
    2'b01, 2'b00, 2'b11, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00
  };

  typedef struct packed {
    logic [DeadW-1:0] deadman_button;
    logic [GapW-1:0]  step_gap_ms;
    logic [GapW-1:0]  disarm_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [MaskW-1:0] button_mask;
    logic [AxisW-1:0] dpad_horizontal;
    logic [AxisW-1:0] dpad_vertical;
  } item_t;

  typedef struct packed {
    logic              go_allowed;
    logic              auto_mode;
    logic [CountW-1:0] sequence_progress;
  } result_t;

endpackage

### design/dmi_state.sv
// Interlock state registers and the per-sample update logic.
module dmi_state #(
  parameter int NUM_BUTTONS = dmi_pkg::NumButtonsDef,
  parameter int SEQ_LEN     = dmi_pkg::SeqLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  dmi_pkg::item_t   item_i,
  input  dmi_pkg::cfg_t    cfg_i,
  output dmi_pkg::result_t res_o
);
  import dmi_pkg::*;

  localparam logic [CountW-1:0] SeqLenC = CountW'(SEQ_LEN);

  logic              go_q, go_d;
  logic              auto_q, auto_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  last_q, last_d;

  logic [MaskW-1:0]  buttons;
  logic              deadman;
  logic [TimeW-1:0]  elapsed;
  logic              gap_over;
  logic              holdoff_over;
  logic [CountW-1:0] count_base;
  logic [3:0]        step_idx;
  logic [AxisW-1:0]  axis_val;

  // Buttons beyond the pad are ignored.
  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < NUM_BUTTONS) begin : g_on
      assign buttons[b] = item_i.button_mask[b];
    end else begin : g_off
      assign buttons[b] = 1'b0;
    end
  end

  assign deadman      = buttons[cfg_i.deadman_button];
  assign elapsed      = item_i.time_ms - last_q;
  assign gap_over     = elapsed > TimeW'(cfg_i.step_gap_ms);
  assign holdoff_over = elapsed > TimeW'(cfg_i.disarm_holdoff_ms);
  assign count_base   = gap_over ? '0 : count_q;
  assign step_idx     = count_base[3:0];
  assign axis_val     = StepIsVert[step_idx] ? item_i.dpad_vertical : item_i.dpad_horizontal;

  always_comb begin
    go_d    = go_q;
    auto_d  = auto_q;
    count_d = count_q;
    last_d  = last_q;
    if (!go_q) begin
      go_d    = auto_q | deadman;
      count_d = count_base;
      if (count_base < SeqLenC) begin
        if (axis_val == StepValue[step_idx]) begin
          count_d = count_base + CountW'(1);
          last_d  = item_i.time_ms;
        end
      end else if (deadman) begin
        count_d = SeqActivated;
      end
      if (count_d == SeqActivated) begin
        auto_d = 1'b1;
      end
    end else if (auto_q) begin
      if ((|buttons) && holdoff_over) begin
        auto_d  = 1'b0;
        count_d = '0;
      end
      if (!auto_d && !deadman) begin
        go_d = 1'b0;
      end
    end else if (!deadman) begin
      go_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q    <= 1'b0;
      auto_q  <= 1'b0;
      count_q <= '0;
      last_q  <= '0;
    end else if (upd_i) begin
      go_q    <= go_d;
      auto_q  <= auto_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign res_o.go_allowed        = go_d;
  assign res_o.auto_mode         = auto_d;
  assign res_o.sequence_progress = count_d;

`include "assert_macros.svh"

  `DMI_ASSERT(a_count_range, (count_q <= SeqLenC) || (count_q == SeqActivated))
  `DMI_ASSERT(a_auto_needs_activation, $rose(auto_q) |-> (count_q == SeqActivated))
  `DMI_ASSERT(a_disarm_clears_count, $fell(auto_q) |-> (count_q == '0))
  `DMI_ASSERT_NEVER(a_auto_while_idle_count, !$past(upd_i) && $rose(auto_q))

endmodule

### design/deadman_interlock_with_unlock_sequence.sv
// Top level of the deadman interlock with unlock sequence.
//
// The block takes one gamepad sample per beat on the s_axis channel and
// returns one result beat per sample on the m_axis channel, in order.
// A sample carries a wrapping millisecond timestamp, the button mask and
// the two D-pad axes; the result gives the desired action, the following
// mode and the unlock-sequence progress (17 once activated).
// An accepted sample lands in an input register; once the output register
// is free, the state update runs and the result enters the output
// register. Throughput is one sample per cycle while the receiver keeps
// up: the state update is a single pass around one 32-bit subtract and
// two 32-bit compares. When the receiver stalls, the output register holds
// its beat and one more sample may wait in the input register before
// s_axis_tready_o drops. Reset empties both registers and clears the
// state: paused, manual, no steps matched, last step time zero; the
// configuration registers return to deadman button 1, a 750 ms step gap
// and a 1000 ms holdoff. Configuration is to be written over the APB port
// by the user only while no sample is in flight; nothing here enforces it.
module deadman_interlock_with_unlock_sequence #(
  parameter int NUM_BUTTONS = dmi_pkg::NumButtonsDef,
  parameter int SEQ_LEN     = dmi_pkg::SeqLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: time_ms[31:0], button_mask[47:32], dpad_horizontal[49:48],
  // dpad_vertical[51:50], zero fill [55:52].
  input  logic [55:0] s_axis_tdata_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: go_allowed[0], auto_mode[1], sequence_progress[6:2], zero [7].
  output logic [7:0]  m_axis_tdata_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dmi_pkg::*;

  // Configuration registers.
  cfg_t    cfg_q;
  logic    cfg_wr;

  // Input register stage.
  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;

  // Output register stage.
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res_next;

  logic    s_accept;
  logic    out_free;
  logic    advance;

  // --------------------------------------------------------------------
  // APB register file. Writes complete in the access phase; the port
  // never stretches a transfer. Writes to an unmapped slot are dropped.
  // --------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadman_button    <= DeadmanRst;
      cfg_q.step_gap_ms       <= StepGapRst;
      cfg_q.disarm_holdoff_ms <= HoldoffRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegDeadman: cfg_q.deadman_button    <= pwdata[DeadW-1:0];
        RegStepGap: cfg_q.step_gap_ms       <= pwdata[GapW-1:0];
        RegHoldoff: cfg_q.disarm_holdoff_ms <= pwdata[GapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDeadman: prdata = 32'(cfg_q.deadman_button);
      RegStepGap: prdata = 32'(cfg_q.step_gap_ms);
      RegHoldoff: prdata = 32'(cfg_q.disarm_holdoff_ms);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------
  // Handshake. The output register frees up when it is empty or its beat
  // is being taken; the input register moves forward whenever the output
  // register is free, so while it is, a new sample can enter every cycle.
  // --------------------------------------------------------------------
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign advance         = in_valid_q & out_free;
  assign s_axis_tready_o = ~in_valid_q | out_free;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.time_ms         <= s_axis_tdata_i[31:0];
      in_item_q.button_mask     <= s_axis_tdata_i[47:32];
      in_item_q.dpad_horizontal <= s_axis_tdata_i[49:48];
      in_item_q.dpad_vertical   <= s_axis_tdata_i[51:50];
    end
    if (advance) begin
      out_res_q <= res_next;
    end
  end

  // --------------------------------------------------------------------
  // State update: commits in the same cycle the result is captured, so
  // the following sample already sees the new state.
  // --------------------------------------------------------------------
  dmi_state #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .SEQ_LEN    (SEQ_LEN)
  ) u_state (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (advance),
    .item_i(in_item_q),
    .cfg_i (cfg_q),
    .res_o (res_next)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q.sequence_progress,
                            out_res_q.auto_mode, out_res_q.go_allowed};

endmodule
